@@ hw/rtl/stp_pkg.sv @@
// Shared types, widths and constants for the sine table PWM generator.
// Used by every module of the block; depends on nothing else.

package stp_pkg;

   // Table and phase sizing.
   localparam int TABLE_POINTS_MAX = 256;
   localparam int PHASE_BITS       = 12;

   localparam int INDEX_W     = $clog2(TABLE_POINTS_MAX);
   localparam int RES_W       = $clog2(TABLE_POINTS_MAX + 1);
   localparam int AMP_W       = 8;
   localparam int DUTY_W      = 8;
   localparam int TICK_W      = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   // The phase holds two quadrant bits above the quarter-wave offset.
   localparam int PHASE_W   = PHASE_BITS + 2;
   localparam int QUARTER_W = PHASE_BITS + 1;
   localparam int X_SHIFT   = 16 - PHASE_BITS;
   localparam int DIV_CNT_W = $clog2(PHASE_W + 1);

   // Q16 arithmetic; one is 65536, so values need 17 bits.
   localparam int Q16_FRAC = 16;
   localparam int Q16_W    = 17;

   // Digit-serial multiplier: 17 by 17 bits, four multiplier bits a cycle.
   localparam int MUL_W      = Q16_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DIGIT_W    = 4;
   localparam int MUL_DIGITS = (MUL_W + DIGIT_W - 1) / DIGIT_W;
   localparam int MUL_LO_W   = MUL_DIGITS * DIGIT_W;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS + 1);
   localparam int PQ_W       = PROD_W - Q16_FRAC;

   // Level before the final scaling: amplitude times a value up to two in Q16.
   localparam int LEV_W = AMP_W + Q16_W;

   localparam logic [QUARTER_W-1:0] QUARTER_ONE = QUARTER_W'(1 << PHASE_BITS);
   localparam logic [Q16_W-1:0]     Q16_ONE     = Q16_W'(65536);
   localparam logic [Q16_W-1:0]     SIN_A       = Q16_W'(102944);
   localparam logic [Q16_W-1:0]     SIN_B       = Q16_W'(42047);
   localparam logic [Q16_W-1:0]     SIN_C       = Q16_W'(4640);

   localparam logic [RES_W-1:0]  RESET_POINTS    = RES_W'(100);
   localparam logic [AMP_W-1:0]  RESET_AMPLITUDE = AMP_W'(255);
   localparam logic [TICK_W-1:0] RESET_INTERVAL  = TICK_W'(100);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POINTS    = 2'd0,
      CSR_AMPLITUDE = 2'd1,
      CSR_INTERVAL  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               start;
      logic [INDEX_W-1:0] dividend;
      logic [RES_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] mcand;
      logic [MUL_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic [INDEX_W-1:0] index;
      logic [RES_W-1:0]   res;
      logic [AMP_W-1:0]   amp;
   } eval_req_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] duty;
   } eval_rsp_type;

endpackage

@@ hw/rtl/stp_phase_div.sv @@
// Bit-serial phase divider: floor(index * 4 * 2^PHASE_BITS / resolution).
// Depends on stp_pkg.

module stp_phase_div (
   input  logic                          clock,
   input  logic                          reset,
   input  stp_pkg::div_req_type          div_req,
   output logic                          div_done,
   output logic [stp_pkg::PHASE_W-1:0]   quotient
);
   import stp_pkg::*;

   logic [RES_W-1:0]     rem_ff, rem_in;
   logic [RES_W-1:0]     divisor_ff, divisor_in;
   logic [PHASE_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff;
   logic [RES_W:0]       rem_x2;
   logic                 fits;

   // Since index < resolution, the remainder after the index bits is the
   // index itself; only the appended zero bits need a step each.
   always_comb begin
      rem_x2     = {rem_ff, 1'b0};
      fits       = rem_x2 >= {1'b0, divisor_ff};
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      if (div_req.start) begin
         rem_in     = RES_W'(div_req.dividend);
         divisor_in = div_req.divisor;
         quo_in     = '0;
         cnt_in     = DIV_CNT_W'(PHASE_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? RES_W'(rem_x2 - {1'b0, divisor_ff}) : rem_x2[RES_W-1:0];
         quo_in = {quo_ff[PHASE_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= !div_req.start && (cnt_ff == DIV_CNT_W'(1));
      end
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/stp_serial_mult.sv @@
// Digit-serial shift-and-add multiplier, one four-bit multiplier digit a cycle.
// Depends on stp_pkg.

module stp_serial_mult (
   input  logic                         clock,
   input  logic                         reset,
   input  stp_pkg::mul_req_type         mul_req,
   output logic                         mul_done,
   output logic [stp_pkg::PROD_W-1:0]   product
);
   import stp_pkg::*;

   logic [MUL_W-1:0]         mcand_ff, mcand_in;
   logic [MUL_W-1:0]         hi_ff, hi_in;
   logic [MUL_LO_W-1:0]      lo_ff, lo_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     done_ff;
   logic [MUL_W+DIGIT_W-1:0] partial;
   logic [MUL_W+DIGIT_W-1:0] sum;
   logic [MUL_W+MUL_LO_W-1:0] full;

   always_comb begin
      partial  = (MUL_W + DIGIT_W)'(mcand_ff) * (MUL_W + DIGIT_W)'(lo_ff[DIGIT_W-1:0]);
      sum      = (MUL_W + DIGIT_W)'(hi_ff) + partial;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      if (mul_req.start) begin
         mcand_in = mul_req.mcand;
         hi_in    = '0;
         lo_in    = MUL_LO_W'(mul_req.mplier);
         cnt_in   = MUL_CNT_W'(MUL_DIGITS);
      end else if (cnt_ff != '0) begin
         // Low digit of the sum drops into the product's low half.
         hi_in  = sum[MUL_W+DIGIT_W-1:DIGIT_W];
         lo_in  = {sum[DIGIT_W-1:0], lo_ff[MUL_LO_W-1:DIGIT_W]};
         cnt_in = cnt_ff - MUL_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= !mul_req.start && (cnt_ff == MUL_CNT_W'(1));
      end
   end

   assign full     = {hi_ff, lo_ff};
   assign product  = full[PROD_W-1:0];
   assign mul_done = done_ff;

endmodule

@@ hw/rtl/stp_sine_eval.sv @@
// Sequencer that turns a point index into a duty value, using the phase
// divider and the shared digit-serial multiplier. Depends on stp_pkg,
// stp_phase_div and stp_serial_mult.

module stp_sine_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  stp_pkg::eval_req_type eval_req,
   output stp_pkg::eval_rsp_type eval_rsp
);
   import stp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_XX,
      S_T,
      S_U,
      S_S,
      S_AS
   } state_type;

   state_type          state_ff;
   div_req_type        div_req;
   mul_req_type        mul_req_ff;
   logic               div_done;
   logic [PHASE_W-1:0] quotient;
   logic               mul_done;
   logic [PROD_W-1:0]  product;

   logic [1:0]            quad_ff;
   logic [AMP_W-1:0]      amp_ff;
   logic [Q16_W-1:0]      x_ff;
   logic [Q16_W-1:0]      x2_ff;
   logic                  done_ff;
   logic [DUTY_W-1:0]     duty_ff;

   logic [1:0]            quad;
   logic [PHASE_BITS-1:0] off;
   logic [QUARTER_W-1:0]  k;
   logic [Q16_W-1:0]      x;
   logic [PQ_W-1:0]       prod_q;
   logic [Q16_W-1:0]      t_val;
   logic [Q16_W-1:0]      u_val;
   logic [Q16_W-1:0]      s_val;
   logic [LEV_W-1:0]      lev_base;
   logic [LEV_W-1:0]      lev_sum;

   assign div_req.start    = eval_req.start && (state_ff == S_IDLE);
   assign div_req.dividend = eval_req.index;
   assign div_req.divisor  = eval_req.res;

   stp_phase_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   stp_serial_mult u_mult (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req_ff),
      .mul_done (mul_done),
      .product  (product)
   );

   // Odd quadrants run the quarter wave backwards; the lower half of the
   // period subtracts the sine from the mid level.
   always_comb begin
      quad     = quotient[PHASE_W-1 -: 2];
      off      = quotient[PHASE_BITS-1:0];
      k        = quad[0] ? (QUARTER_ONE - {1'b0, off}) : {1'b0, off};
      x        = Q16_W'(k) << X_SHIFT;
      prod_q   = product[PROD_W-1:Q16_FRAC];
      t_val    = SIN_B - Q16_W'(prod_q);
      u_val    = SIN_A - Q16_W'(prod_q);
      s_val    = (prod_q > PQ_W'(Q16_ONE)) ? Q16_ONE : Q16_W'(prod_q);
      lev_base = LEV_W'(amp_ff) << Q16_FRAC;
      lev_sum  = quad_ff[1] ? (lev_base - product[LEV_W-1:0])
                            : (lev_base + product[LEV_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         mul_req_ff.start <= 1'b0;
         done_ff          <= 1'b0;
      end else begin
         mul_req_ff.start <= 1'b0;
         done_ff          <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (eval_req.start) begin
                  amp_ff   <= eval_req.amp;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  quad_ff           <= quad;
                  x_ff              <= x;
                  mul_req_ff.start  <= 1'b1;
                  mul_req_ff.mcand  <= x;
                  mul_req_ff.mplier <= x;
                  state_ff          <= S_XX;
               end
            end
            S_XX: begin
               if (mul_done) begin
                  x2_ff             <= Q16_W'(prod_q);
                  mul_req_ff.start  <= 1'b1;
                  mul_req_ff.mcand  <= SIN_C;
                  mul_req_ff.mplier <= Q16_W'(prod_q);
                  state_ff          <= S_T;
               end
            end
            S_T: begin
               if (mul_done) begin
                  mul_req_ff.start  <= 1'b1;
                  mul_req_ff.mcand  <= t_val;
                  mul_req_ff.mplier <= x2_ff;
                  state_ff          <= S_U;
               end
            end
            S_U: begin
               if (mul_done) begin
                  mul_req_ff.start  <= 1'b1;
                  mul_req_ff.mcand  <= u_val;
                  mul_req_ff.mplier <= x_ff;
                  state_ff          <= S_S;
               end
            end
            S_S: begin
               if (mul_done) begin
                  mul_req_ff.start  <= 1'b1;
                  mul_req_ff.mcand  <= s_val;
                  mul_req_ff.mplier <= MUL_W'(amp_ff);
                  state_ff          <= S_AS;
               end
            end
            S_AS: begin
               if (mul_done) begin
                  duty_ff  <= lev_sum[LEV_W-1 -: DUTY_W];
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign eval_rsp.done = done_ff;
   assign eval_rsp.duty = duty_ff;

endmodule

@@ hw/rtl/sine_table_pwm_generator.sv @@
// Top level of the sine table PWM generator: register file, tick counter,
// point index and result register. Depends on stp_pkg and stp_sine_eval.
//
// Each req_ word is one step of a microsecond timebase (req_time_step high
// means a microsecond has passed). Ticks are counted since the last output
// point; once the count reaches interval_ticks the block clears it and
// sends one rsp_ word holding the PWM duty for the current point,
// floor(A * (1 + sin(2*pi*i/R)) / 2) with the sine worked in Q16 fixed
// point, together with the point number i, which then advances modulo R.
// A word that emits nothing leaves the block idle, so the next req_ word can
// be taken in the cycle after. A word that emits a point holds req_ready low
// until its point is in the rsp_ register, so no req_ word is taken while a
// point is worked out. The steps run in order: a register starts the
// sequencer; the phase divider loads and then forms one quotient bit a cycle
// for 14 bits; the shared multiplier forms five products one after another,
// each a load, five digits of four bits and a step to pass the product on;
// and the duty moves into the rsp_ register. A finished point waits in the
// rsp_ register without holding up the next req_ word; only when that
// register is still full as the next duty is ready does the block hold
// req_ready low until it drains. Configuration words are taken whenever the
// block is idle, ahead of a req_ word offered in the same cycle. Register 0
// sets points per period from the low nine data bits (1 to 256; any other
// value there is ignored and changes nothing), register 1 the peak amplitude
// and register 2 the interval in ticks. Every effective write restarts both
// the tick count and the point index. With an interval of zero every req_
// word emits a point, whatever its time step.

module sine_table_pwm_generator (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_time_step,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [stp_pkg::DUTY_W-1:0]        rsp_duty_value,
   output logic [stp_pkg::INDEX_W-1:0]       rsp_point_number,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import stp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_PEND
   } state_type;

   state_type          state_ff;

   // Configuration registers.
   logic [RES_W-1:0]   points_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic [TICK_W-1:0]  interval_ff;

   // Running state.
   logic [TICK_W-1:0]  tick_ff;
   logic [INDEX_W-1:0] index_ff;
   logic [INDEX_W-1:0] calc_index_ff;
   logic               eval_start_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [DUTY_W-1:0]  rsp_duty_ff;
   logic [INDEX_W-1:0] rsp_num_ff;

   logic [TICK_W-1:0]  tick_in;
   logic               emit;
   logic [RES_W-1:0]   index_inc;
   logic [INDEX_W-1:0] index_in;
   logic [RES_W-1:0]   new_points;
   logic               points_ok;
   logic               slot_free;

   eval_req_type       eval_req;
   eval_rsp_type       eval_rsp;

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // The tick count wraps at its own width; the comparison is made on every
   // word, so a zero interval emits even when no time has passed.
   always_comb begin
      tick_in    = tick_ff + TICK_W'(req_time_step);
      emit       = tick_in >= interval_ff;
      index_inc  = RES_W'(index_ff) + RES_W'(1);
      index_in   = (index_inc == points_ff) ? '0 : index_inc[INDEX_W-1:0];
      new_points = csr_wdata[RES_W-1:0];
      points_ok  = (new_points != '0) && (new_points <= RES_W'(TABLE_POINTS_MAX));
   end

   assign eval_req.start = eval_start_ff;
   assign eval_req.index = calc_index_ff;
   assign eval_req.res   = points_ff;
   assign eval_req.amp   = amp_ff;

   stp_sine_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .eval_req (eval_req),
      .eval_rsp (eval_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         points_ff     <= RESET_POINTS;
         amp_ff        <= RESET_AMPLITUDE;
         interval_ff   <= RESET_INTERVAL;
         tick_ff       <= '0;
         index_ff      <= '0;
         eval_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eval_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  unique case (csr_index)
                     CSR_POINTS: begin
                        if (points_ok) begin
                           points_ff <= new_points;
                           tick_ff   <= '0;
                           index_ff  <= '0;
                        end
                     end
                     CSR_AMPLITUDE: begin
                        amp_ff   <= csr_wdata[AMP_W-1:0];
                        tick_ff  <= '0;
                        index_ff <= '0;
                     end
                     CSR_INTERVAL: begin
                        interval_ff <= csr_wdata[TICK_W-1:0];
                        tick_ff     <= '0;
                        index_ff    <= '0;
                     end
                     default: begin
                     end
                  endcase
               end else if (req_valid) begin
                  if (emit) begin
                     tick_ff       <= '0;
                     calc_index_ff <= index_ff;
                     index_ff      <= index_in;
                     eval_start_ff <= 1'b1;
                     state_ff      <= ST_CALC;
                  end else begin
                     tick_ff <= tick_in;
                  end
               end
            end
            ST_CALC: begin
               if (eval_rsp.done) begin
                  if (slot_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_duty_ff  <= eval_rsp.duty;
                     rsp_num_ff   <= calc_index_ff;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_PEND;
                  end
               end
            end
            ST_PEND: begin
               // The sequencer holds its duty until it is started again.
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_duty_ff  <= eval_rsp.duty;
                  rsp_num_ff   <= calc_index_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_duty_value   = rsp_duty_ff;
   assign rsp_point_number = rsp_num_ff;

endmodule
